@@ hdl/bsa_pkg.sv @@
// shared constants, result codes and control/status types for the slot allocator
package bsa_pkg;

  localparam int NUM_SLOTS  = 256;
  localparam int SLOT_BYTES = 16;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int MAP_BYTES  = NUM_SLOTS / 8;
  localparam int BYTE_IDX_W = $clog2(MAP_BYTES);
  localparam int RUN_W      = 9;
  localparam int SIZE_W     = 13;
  localparam int COUNT_W    = 13;
  localparam int CAPACITY   = NUM_SLOTS * SLOT_BYTES;

  localparam logic [7:0] FULL_BYTE = 8'hFF;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [1:0] ST_ZERO_SIZE = 2'd3;

  typedef struct packed {
    logic       latch_in;
    logic       start_scan;
    logic       scan_step;
    logic       load_len;
    logic       mark_step;
    logic       commit;
    logic       load_out;
    logic [1:0] out_status;
  } bsa_cmd_t;

  typedef struct packed {
    logic kind;
    logic zero_size;
    logic short_space;
    logic rec_valid;
    logic found;
    logic scan_last;
    logic mark_last;
  } bsa_stat_t;

endpackage

@@ hdl/bitmap_slot_allocator_top.sv @@
// first-fit slot allocator over a 256-slot pool of 16-byte slots
//
// input channel (in_valid/in_ready): one transfer carries kind, size_bytes and
// slot_address. kind allocate asks for size_bytes rounded up to whole slots;
// kind free releases the run that starts at slot_address.
// output channel (out_valid/out_ready): exactly one result transfer per item
// with status, start_slot, run_slots and the used byte total after the item.
// one item is processed at a time; in_ready is high only while idle.
// sequence: errors found at the size or record check go from the decode state
// straight to the result; a free loads the run length, marks the map bytes the
// run spans and commits; an allocate scans map bytes (one per cycle, up to 32),
// marks the map bytes the run spans and commits. the map walk works over
// single bytes.
// a result waiting in the output register does not stop the next input
// transfer; only the following result waits until out_ready takes the first.
// reset (rst, synchronous): every slot free, no recorded runs, zero bytes
// used, no result pending.
module bitmap_slot_allocator_top import bsa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [SIZE_W-1:0]  size_bytes,
  input  logic [SLOT_W-1:0]  slot_address,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [SLOT_W-1:0]  start_slot,
  output logic [RUN_W-1:0]   run_slots,
  output logic [COUNT_W-1:0] used_bytes
);

  bsa_cmd_t  cmd;
  bsa_stat_t stat;

  // sequencer: one item at a time, owns both handshakes
  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // map, records, byte count and result register
  bsa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .kind_in    (kind),
    .size_in    (size_bytes),
    .addr_in    (slot_address),
    .status     (status),
    .start_slot (start_slot),
    .run_slots  (run_slots),
    .used_bytes (used_bytes)
  );

`ifndef ASSERT_OFF
  // a granted or released run is never empty
  a_ok_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> run_slots != '0)
    else $error("ok result with empty run");

  // failed items report no run
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> run_slots == '0 && start_slot == '0)
    else $error("failed result carries a run");

  // byte total never exceeds the pool
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, used_bytes} <= (COUNT_W+1)'(CAPACITY))
    else $error("used bytes beyond pool capacity");

  // in the cycle after an input transfer the block is busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");
`endif

endmodule

@@ hdl/bsa_dp.sv @@
// allocator datapath: used map, run records, byte counter, scan and mark logic
module bsa_dp import bsa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  bsa_cmd_t            cmd,
  output bsa_stat_t           stat,
  input  logic                kind_in,
  input  logic [SIZE_W-1:0]   size_in,
  input  logic [SLOT_W-1:0]   addr_in,
  output logic [1:0]          status,
  output logic [SLOT_W-1:0]   start_slot,
  output logic [RUN_W-1:0]    run_slots,
  output logic [COUNT_W-1:0]  used_bytes
);

  logic                  kind_r;
  logic [SIZE_W-1:0]     size_r;
  logic [SLOT_W-1:0]     addr_r;
  logic [NUM_SLOTS-1:0]  used_map;
  logic [NUM_SLOTS-1:0]  rec_valid;
  logic [RUN_W-1:0]      rec_mem [0:NUM_SLOTS-1];
  logic [RUN_W-1:0]      rd_data;
  logic [COUNT_W-1:0]    used_count;
  logic [BYTE_IDX_W-1:0] byte_idx;
  logic [RUN_W-1:0]      run_len;
  logic [SLOT_W-1:0]     run_start;
  logic [RUN_W-1:0]      mark_len;

  logic [SIZE_W:0]       need_sum;
  logic [SIZE_W:0]       need_full;
  logic [RUN_W-1:0]      need;
  logic [COUNT_W-1:0]    free_bytes;
  logic [7:0]            map_byte;
  logic [RUN_W-1:0]      scan_len;
  logic [SLOT_W-1:0]     scan_st;
  logic                  scan_found;
  logic [RUN_W-1:0]      mark_end;
  logic [RUN_W-1:0]      mark_tail;
  logic [7:0]            mark_mask;
  logic [7:0]            new_byte;
  logic [COUNT_W-1:0]    run_bytes;

  // slots needed, rounded up
  assign need_sum   = {1'b0, size_r} + (SIZE_W+1)'(SLOT_BYTES - 1);
  assign need_full  = need_sum / (SIZE_W+1)'(SLOT_BYTES);
  assign need       = need_full[RUN_W-1:0];
  assign free_bytes = COUNT_W'(CAPACITY) - used_count;
  assign map_byte   = used_map[{byte_idx, 3'b000} +: 8];

  // first-fit walk over one map byte
  always_comb begin
    scan_len   = run_len;
    scan_st    = run_start;
    scan_found = 1'b0;
    if (map_byte == FULL_BYTE) begin
      scan_len = '0;
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (!scan_found) begin
          if (map_byte[i]) begin
            scan_len = '0;
          end else begin
            if (scan_len == '0) scan_st = {byte_idx, 3'(i)};
            scan_len = scan_len + 1'b1;
            if (scan_len >= need) scan_found = 1'b1;
          end
        end
      end
    end
  end

  // slots of the current byte that fall inside the run
  assign mark_end  = {1'b0, run_start} + mark_len;
  assign mark_tail = mark_end - RUN_W'(1);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mark_mask[i] = ({byte_idx, 3'(i)} >= run_start) &&
                     ({1'b0, byte_idx, 3'(i)} < mark_end);
    end
  end

  assign new_byte  = (kind_r == KIND_ALLOC) ? (map_byte | mark_mask) : (map_byte & ~mark_mask);
  assign run_bytes = COUNT_W'(mark_len * SLOT_BYTES);

  assign stat.kind        = kind_r;
  assign stat.zero_size   = (size_r == '0);
  assign stat.short_space = ({1'b0, size_r} > {1'b0, free_bytes});
  assign stat.rec_valid   = rec_valid[addr_r];
  assign stat.found       = scan_found;
  assign stat.scan_last   = (byte_idx == BYTE_IDX_W'(MAP_BYTES - 1));
  assign stat.mark_last   = (byte_idx == mark_tail[SLOT_W-1:3]);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used_map   <= '0;
      rec_valid  <= '0;
      used_count <= '0;
    end else begin
      if (cmd.mark_step) used_map[{byte_idx, 3'b000} +: 8] <= new_byte;
      if (cmd.commit) begin
        if (kind_r == KIND_ALLOC) begin
          rec_valid[run_start] <= 1'b1;
          used_count           <= used_count + run_bytes;
        end else begin
          rec_valid[run_start] <= 1'b0;
          used_count           <= (used_count > run_bytes) ? used_count - run_bytes : '0;
        end
      end
    end
  end

  // run length records
  always_ff @(posedge clk) begin
    if (cmd.commit && kind_r == KIND_ALLOC) rec_mem[run_start] <= mark_len;
    rd_data <= rec_mem[addr_r];
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= kind_in;
      size_r <= size_in;
      addr_r <= addr_in;
    end
    if (cmd.start_scan) begin
      byte_idx  <= '0;
      run_len   <= '0;
      run_start <= '0;
    end
    if (cmd.scan_step) begin
      run_len   <= scan_len;
      run_start <= scan_st;
      if (scan_found) begin
        mark_len <= need;
        byte_idx <= scan_st[SLOT_W-1:3];
      end else begin
        byte_idx <= byte_idx + 1'b1;
      end
    end
    if (cmd.load_len) begin
      mark_len  <= rd_data;
      run_start <= addr_r;
      byte_idx  <= addr_r[SLOT_W-1:3];
    end
    if (cmd.mark_step) byte_idx <= byte_idx + 1'b1;
    if (cmd.load_out) begin
      status     <= cmd.out_status;
      used_bytes <= used_count;
      if (cmd.out_status == ST_OK) begin
        start_slot <= run_start;
        run_slots  <= mark_len;
      end else begin
        start_slot <= '0;
        run_slots  <= '0;
      end
    end
  end

endmodule

@@ hdl/bsa_ctrl.sv @@
// allocator controller: sequences check, scan, mark, commit and result transfer
module bsa_ctrl import bsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output bsa_cmd_t  cmd,
  input  bsa_stat_t stat
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_FREE_LEN = 3'd3;
  localparam logic [2:0] S_MARK     = 3'd4;
  localparam logic [2:0] S_COMMIT   = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] status_r;
  logic [1:0] status_r_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    status_r_next = status_r;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.kind == KIND_ALLOC) begin
          if (stat.zero_size) begin
            status_r_next = ST_ZERO_SIZE;
            state_next    = S_OUT;
          end else if (stat.short_space) begin
            status_r_next = ST_NO_SPACE;
            state_next    = S_OUT;
          end else begin
            cmd.start_scan = 1'b1;
            state_next     = S_SCAN;
          end
        end else if (!stat.rec_valid) begin
          status_r_next = ST_NOT_ALLOC;
          state_next    = S_OUT;
        end else begin
          state_next = S_FREE_LEN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.found) begin
          state_next = S_MARK;
        end else if (stat.scan_last) begin
          status_r_next = ST_NO_SPACE;
          state_next    = S_OUT;
        end
      end
      S_FREE_LEN: begin
        cmd.load_len = 1'b1;
        state_next   = S_MARK;
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (stat.mark_last) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit    = 1'b1;
        status_r_next = ST_OK;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.out_status = status_r;
  end

  assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status_r  <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      status_r  <= status_r_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
